// ===== sv/mer_pkg.sv =====
// Shared types and constants for the midpoint ellipse rasterizer.
// Holds the request and result structs, datapath opcodes and the
// command/status structs that join the controller and the datapath.
`default_nettype none

package mer_pkg;

  localparam int unsigned CoordBits  = 10;
  localparam int unsigned RadiusBits = 9;
  localparam int unsigned PixBits    = 12;

  // Request action codes.
  localparam logic ActStart = 1'b0;

  typedef struct packed {
    logic                  action;
    logic [CoordBits-1:0]  center_x;
    logic [CoordBits-1:0]  center_y;
    logic [RadiusBits-1:0] radius_x;
    logic [RadiusBits-1:0] radius_y;
  } mer_in_t;

  typedef struct packed {
    logic signed [PixBits-1:0] pixel_x;
    logic signed [PixBits-1:0] pixel_y;
    logic                      last;
    logic                      finished;
  } mer_out_t;

  // Datapath operations issued by the controller.
  localparam logic [4:0] OpNop       = 5'd0;
  localparam logic [4:0] OpLoad      = 5'd1;
  localparam logic [4:0] OpSqRx      = 5'd2;
  localparam logic [4:0] OpSqRy      = 5'd3;
  localparam logic [4:0] OpMulRx2Ry  = 5'd4;
  localparam logic [4:0] OpInit      = 5'd5;
  localparam logic [4:0] OpMulTx     = 5'd6;
  localparam logic [4:0] OpMulRy2T   = 5'd7;
  localparam logic [4:0] OpMulTy     = 5'd8;
  localparam logic [4:0] OpMulRx2T   = 5'd9;
  localparam logic [4:0] OpMulRx2Ry2 = 5'd10;
  localparam logic [4:0] OpEnterR2   = 5'd11;
  localparam logic [4:0] OpR1Move    = 5'd12;
  localparam logic [4:0] OpR2Move    = 5'd13;
  localparam logic [4:0] OpUpdate    = 5'd14;
  localparam logic [4:0] OpStop      = 5'd15;
  localparam logic [4:0] OpEmit      = 5'd16;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] idx;   // bit 1: mirror x, bit 0: mirror y
    logic       last;
    logic       fin;
  } mer_cmd_t;

  typedef struct packed {
    logic active;
    logic region2;
    logic px_lt_py;
    logic y_nz;
    logic out_ready;
  } mer_stat_t;

endpackage

`default_nettype wire

// ===== sv/mer_ctrl.sv =====
// Controller of the midpoint ellipse rasterizer: sequences the shared
// multiplier, the region updates and the result emission.
// Depends on mer_pkg for the command and status structs.
`default_nettype none

module mer_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_action_i,
  output logic                   in_stall_o,
  input  wire mer_pkg::mer_stat_t stat_i,
  output mer_pkg::mer_cmd_t      cmd_o
);
  import mer_pkg::*;

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StSqRx     = 4'd1;
  localparam logic [3:0] StSqRy     = 4'd2;
  localparam logic [3:0] StMulRy    = 4'd3;
  localparam logic [3:0] StInit     = 4'd4;
  localparam logic [3:0] StR1Chk    = 4'd5;
  localparam logic [3:0] StRy2T     = 4'd6;
  localparam logic [3:0] StTy       = 4'd7;
  localparam logic [3:0] StRx2T     = 4'd8;
  localparam logic [3:0] StRx2Ry2   = 4'd9;
  localparam logic [3:0] StEnterR2  = 4'd10;
  localparam logic [3:0] StR2Chk    = 4'd11;
  localparam logic [3:0] StUpdate   = 4'd12;
  localparam logic [3:0] StEmit     = 4'd13;

  localparam logic [1:0] EkStart = 2'd0;
  localparam logic [1:0] EkFour  = 2'd1;
  localparam logic [1:0] EkFin   = 2'd2;

  logic [3:0] state_q, state_d;
  logic [1:0] kind_q, kind_d;
  logic [1:0] idx_q, idx_d;
  logic       emit_last;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    emit_last = (kind_q == EkFin) ||
                ((kind_q == EkStart) && (idx_q == 2'd1)) ||
                ((kind_q == EkFour) && (idx_q == 2'd3));
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    idx_d      = idx_q;
    cmd_o.op   = OpNop;
    cmd_o.idx  = idx_q;
    cmd_o.last = emit_last;
    cmd_o.fin  = (kind_q == EkFin);
    case (state_q)
      StIdle: begin
        idx_d = 2'd0;
        if (in_valid_i) begin
          if (in_action_i == ActStart) begin
            cmd_o.op = OpLoad;
            state_d  = StSqRx;
          end else if (!stat_i.active) begin
            kind_d  = EkFin;
            state_d = StEmit;
          end else if (stat_i.region2) begin
            state_d = StR2Chk;
          end else begin
            state_d = StR1Chk;
          end
        end
      end
      StSqRx: begin
        cmd_o.op = OpSqRx;
        state_d  = StSqRy;
      end
      StSqRy: begin
        cmd_o.op = OpSqRy;
        state_d  = StMulRy;
      end
      StMulRy: begin
        cmd_o.op = OpMulRx2Ry;
        state_d  = StInit;
      end
      StInit: begin
        cmd_o.op = OpInit;
        kind_d   = EkStart;
        state_d  = StEmit;
      end
      StR1Chk: begin
        if (stat_i.px_lt_py) begin
          cmd_o.op = OpR1Move;
          state_d  = StUpdate;
        end else begin
          cmd_o.op = OpMulTx;
          state_d  = StRy2T;
        end
      end
      StRy2T: begin
        cmd_o.op = OpMulRy2T;
        state_d  = StTy;
      end
      StTy: begin
        cmd_o.op = OpMulTy;
        state_d  = StRx2T;
      end
      StRx2T: begin
        cmd_o.op = OpMulRx2T;
        state_d  = StRx2Ry2;
      end
      StRx2Ry2: begin
        cmd_o.op = OpMulRx2Ry2;
        state_d  = StEnterR2;
      end
      StEnterR2: begin
        cmd_o.op = OpEnterR2;
        state_d  = StR2Chk;
      end
      StR2Chk: begin
        if (stat_i.y_nz) begin
          cmd_o.op = OpR2Move;
          state_d  = StUpdate;
        end else begin
          cmd_o.op = OpStop;
          kind_d   = EkFin;
          state_d  = StEmit;
        end
      end
      StUpdate: begin
        cmd_o.op = OpUpdate;
        kind_d   = EkFour;
        state_d  = StEmit;
      end
      StEmit: begin
        if (stat_i.out_ready) begin
          cmd_o.op = OpEmit;
          idx_d    = idx_q + 2'd1;
          if (emit_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      kind_q  <= EkStart;
      idx_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mer_dp.sv =====
// Datapath of the midpoint ellipse rasterizer: saved geometry, offsets,
// incremental terms, the decision value, one shared multiplier and the
// result register. Depends on mer_pkg; driven by mer_ctrl commands.
`default_nettype none

module mer_dp #(
  parameter int unsigned MAX_RADIUS_BITS = mer_pkg::RadiusBits,
  parameter int unsigned COORD_BITS      = mer_pkg::CoordBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mer_pkg::mer_in_t   in_data_i,
  input  wire mer_pkg::mer_cmd_t  cmd_i,
  output mer_pkg::mer_stat_t      stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mer_pkg::mer_out_t       out_data_o
);
  import mer_pkg::*;

  localparam int unsigned R   = MAX_RADIUS_BITS;
  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned XW  = R + 1;       // offsets
  localparam int unsigned SQW = 2 * R;       // squared radii
  localparam int unsigned PW  = 3 * R + 2;   // 2*ry^2*x and 2*rx^2*y
  localparam int unsigned MA  = 2 * R;       // multiplier operand A
  localparam int unsigned MB  = 2 * R + 4;   // multiplier operand B
  localparam int unsigned MP  = MA + MB;     // product
  localparam int unsigned DW  = 4 * R + 12;  // decision value times four
  localparam int unsigned EW  = C + R + 2;   // pixel arithmetic

  logic [C-1:0]   cx_q, cy_q;
  logic [R-1:0]   rx_q, ry_q;
  logic [SQW-1:0] rx2_q, ry2_q;
  logic [XW-1:0]  x_q, y_q;
  logic [PW-1:0]  px_q, py_q;
  logic [MP-1:0]  p_q;
  logic signed [DW-1:0] d_q;
  logic           alt_q;
  logic           active_q, region2_q, out_valid_q;
  mer_out_t       out_q, out_d;

  logic [MA-1:0]  mul_a;
  logic [MB-1:0]  mul_b;
  logic [MP-1:0]  prod;
  logic [XW:0]    tx;
  logic [XW-1:0]  aty;
  logic [PW-1:0]  two_rx2, two_ry2;
  logic signed [DW-1:0] rx2_s, ry2_s, px_s, py_s, p_s;
  logic           d_neg, d_pos, out_ready;
  logic [EW-1:0]  cx_e, cy_e, x_e, y_e, sum_x, sum_y;

  assign tx      = {x_q, 1'b1};
  assign aty     = (y_q == '0) ? XW'(1) : (y_q - XW'(1));
  assign two_rx2 = PW'({rx2_q, 1'b0});
  assign two_ry2 = PW'({ry2_q, 1'b0});
  assign rx2_s   = DW'(rx2_q);
  assign ry2_s   = DW'(ry2_q);
  assign px_s    = DW'(px_q);
  assign py_s    = DW'(py_q);
  assign p_s     = DW'(p_q);
  assign d_neg   = d_q[DW-1];
  assign d_pos   = !d_neg && (d_q != '0);

  assign out_ready = !out_valid_q || !out_stall_i;

  assign stat_o.active    = active_q;
  assign stat_o.region2   = region2_q;
  assign stat_o.px_lt_py  = (px_q < py_q);
  assign stat_o.y_nz      = (y_q != '0);
  assign stat_o.out_ready = out_ready;

  // Shared multiplier; every product is registered in p_q.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OpSqRx: begin
        mul_a = MA'(rx_q);
        mul_b = MB'(rx_q);
      end
      OpSqRy: begin
        mul_a = MA'(ry_q);
        mul_b = MB'(ry_q);
      end
      OpMulRx2Ry: begin
        mul_a = rx2_q;
        mul_b = MB'(ry_q);
      end
      OpMulTx: begin
        mul_a = MA'(tx);
        mul_b = MB'(tx);
      end
      OpMulRy2T: begin
        mul_a = ry2_q;
        mul_b = p_q[MB-1:0];
      end
      OpMulTy: begin
        mul_a = MA'(aty);
        mul_b = MB'(aty);
      end
      OpMulRx2T: begin
        mul_a = rx2_q;
        mul_b = p_q[MB-1:0];
      end
      OpMulRx2Ry2: begin
        mul_a = rx2_q;
        mul_b = MB'(ry2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = MP'(mul_a) * MP'(mul_b);

  // Mirrored point: idx bit 1 negates the x offset, bit 0 the y offset.
  assign cx_e  = EW'(cx_q);
  assign cy_e  = EW'(cy_q);
  assign x_e   = EW'(x_q);
  assign y_e   = EW'(y_q);
  assign sum_x = cmd_i.idx[1] ? (cx_e - x_e) : (cx_e + x_e);
  assign sum_y = cmd_i.idx[0] ? (cy_e - y_e) : (cy_e + y_e);

  always_comb begin
    out_d.last     = cmd_i.last;
    out_d.finished = cmd_i.fin;
    if (cmd_i.fin) begin
      out_d.pixel_x = '0;
      out_d.pixel_y = '0;
    end else begin
      out_d.pixel_x = signed'(sum_x[PixBits-1:0]);
      out_d.pixel_y = signed'(sum_y[PixBits-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      region2_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OpEmit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OpLoad: begin
          active_q  <= 1'b1;
          region2_q <= 1'b0;
        end
        OpEnterR2: begin
          region2_q <= 1'b1;
        end
        OpStop: begin
          active_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpEmit) begin
      out_q <= out_d;
    end
    if (cmd_i.op inside {OpSqRx, OpSqRy, OpMulRx2Ry, OpMulTx, OpMulRy2T, OpMulTy,
                         OpMulRx2T, OpMulRx2Ry2}) begin
      p_q <= prod;
    end
    case (cmd_i.op)
      OpLoad: begin
        cx_q <= C'(in_data_i.center_x);
        cy_q <= C'(in_data_i.center_y);
        rx_q <= R'(in_data_i.radius_x);
        ry_q <= R'(in_data_i.radius_y);
        x_q  <= '0;
        y_q  <= XW'(R'(in_data_i.radius_y));
      end
      OpSqRy: begin
        rx2_q <= p_q[SQW-1:0];
      end
      OpMulRx2Ry: begin
        ry2_q <= p_q[SQW-1:0];
      end
      OpInit: begin
        d_q  <= (ry2_s <<< 2) - (p_s <<< 2) + rx2_s;
        px_q <= '0;
        py_q <= PW'({p_q, 1'b0});
      end
      OpMulTy: begin
        d_q <= p_s;
      end
      OpMulRx2Ry2: begin
        d_q <= d_q + (p_s <<< 2);
      end
      OpEnterR2: begin
        d_q <= d_q - (p_s <<< 2);
      end
      OpR1Move: begin
        x_q   <= x_q + XW'(1);
        px_q  <= px_q + two_ry2;
        alt_q <= !d_neg;
        if (!d_neg) begin
          y_q  <= y_q - XW'(1);
          py_q <= py_q - two_rx2;
        end
      end
      OpR2Move: begin
        y_q   <= y_q - XW'(1);
        py_q  <= py_q - two_rx2;
        alt_q <= !d_pos;
        if (!d_pos) begin
          x_q  <= x_q + XW'(1);
          px_q <= px_q + two_ry2;
        end
      end
      OpUpdate: begin
        // px and py already hold the moved offsets at this point.
        if (region2_q) begin
          d_q <= d_q + ((rx2_s - py_s) <<< 2) + (alt_q ? (px_s <<< 2) : '0);
        end else begin
          d_q <= d_q + ((px_s + ry2_s) <<< 2) - (alt_q ? (py_s <<< 2) : '0);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/midpoint_ellipse_rasterizer.sv =====
// Top level of the midpoint ellipse rasterizer.
// Instantiates mer_ctrl and mer_dp; types come from mer_pkg.
//
// Usage: a request with action start latches the center and the radii and
// returns two results (top and bottom points, last on the second). A step
// request advances the two-region midpoint iteration and returns the four
// mirrored points, last on the fourth. A step once the ellipse is done, or
// before any start, returns one result with finished and last set.
// Both channels use valid/stall; a request is taken only while in_stall_o
// is low, and the block works on one request at a time.
// The pace is set by the single shared multiplier, which takes one
// product per cycle, and by the one result register, which issues one
// result per cycle while the receiver does not stall.
// Reset clears the controller, the drawing flags and the result valid, so
// the block comes out idle. While the receiver stalls, the pending result
// holds and the sequencer waits before it emits the next result.
`default_nettype none

module midpoint_ellipse_rasterizer #(
  parameter int unsigned MAX_RADIUS_BITS = mer_pkg::RadiusBits,
  parameter int unsigned COORD_BITS      = mer_pkg::CoordBits
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire mer_pkg::mer_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output mer_pkg::mer_out_t      out_data_o
);
  import mer_pkg::*;

  mer_cmd_t  cmd;
  mer_stat_t stat;

  mer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mer_dp #(
    .MAX_RADIUS_BITS (MAX_RADIUS_BITS),
    .COORD_BITS      (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== sv/mer_checker.sv =====
// Port-level checks for the midpoint ellipse rasterizer, bound to the top.
// Depends on mer_pkg for the request and result structs.
`default_nettype none

module mer_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire mer_pkg::mer_in_t in_data_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire mer_pkg::mer_out_t out_data_o
);
  import mer_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // Only one request is in work at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.action == ActStart || 1'b1) |=> in_stall_o)
    else $error("request taken while the previous one is in work");

  a_fin_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.finished |->
      out_data_o.last && (out_data_o.pixel_x == '0) && (out_data_o.pixel_y == '0))
    else $error("finished result malformed");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
